// ===== hdl/cmfa_pkg.sv =====
// Shared constants for the cube-map face address unit: field widths, face codes
// and the configuration register map.
// No dependencies.
`default_nettype none

package cmfa_pkg;

    // direction component width (signed Q1.14)
    localparam int DIR_W = 16;
    // face code width
    localparam int FACE_W = 3;
    // bits of pwdata kept by a face_size write
    localparam int CFG_W = 13;
    // APB data and address widths
    localparam int APB_DW = 32;
    localparam int ADDR_W = 3;

    typedef logic [FACE_W-1:0] t_face;

    // face codes
    localparam t_face FACE_PX = 3'd0;
    localparam t_face FACE_NX = 3'd1;
    localparam t_face FACE_PY = 3'd2;
    localparam t_face FACE_NY = 3'd3;
    localparam t_face FACE_PZ = 3'd4;
    localparam t_face FACE_NZ = 3'd5;

    // register map (byte addresses)
    localparam logic [ADDR_W-1:0] ADDR_FACE_SIZE = 3'd0;

endpackage

`default_nettype wire

// ===== hdl/cube_map_face_address_top.sv =====
// Cube-map face address unit: major-axis face select, pipelined face-coordinate
// division, texel scaling and clamping. Depends on cmfa_pkg.
//
// Channel   Direction  Handshake                Payload
// request   in         start (busy held low)    i_dir_x, i_dir_y, i_dir_z
// result    out        o_valid strobe, 1 cycle  o_face .. o_zero_vector
// config    in/out     APB, pready always high  face_size at byte address 0
//
// One request per cycle; each result passes the capture, select and
// integer-quotient stages, the division pipeline of NDIV stages (four quotient
// bits per stage), then the multiply and clamp stages. Reset (synchronous)
// clears all valid bits and sets face_size to 256, or to MAX_FACE_SIZE if that
// is smaller. The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module cube_map_face_address_top #(
    parameter int MAX_FACE_SIZE   = 4096,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    // request channel
    input  wire                                      start,
    output logic                                     busy,
    input  wire  signed [cmfa_pkg::DIR_W-1:0]        i_dir_x,
    input  wire  signed [cmfa_pkg::DIR_W-1:0]        i_dir_y,
    input  wire  signed [cmfa_pkg::DIR_W-1:0]        i_dir_z,
    // configuration port
    input  wire                                      psel,
    input  wire                                      penable,
    input  wire                                      pwrite,
    input  wire  [cmfa_pkg::ADDR_W-1:0]              paddr,
    input  wire  [cmfa_pkg::APB_DW-1:0]              pwdata,
    output logic [cmfa_pkg::APB_DW-1:0]              prdata,
    output logic                                     pready,
    // result channel
    output logic                                     o_valid,
    output logic [cmfa_pkg::FACE_W-1:0]              o_face,
    output logic [COORD_FRAC_BITS:0]                 o_coord_s,
    output logic [COORD_FRAC_BITS:0]                 o_coord_t,
    output logic [$clog2(MAX_FACE_SIZE)-1:0]         o_texel_x,
    output logic [$clog2(MAX_FACE_SIZE)-1:0]         o_texel_y,
    output logic [COORD_FRAC_BITS-1:0]               o_frac_x,
    output logic [COORD_FRAC_BITS-1:0]               o_frac_y,
    output logic                                     o_zero_vector
);

    localparam int DW    = cmfa_pkg::DIR_W;
    localparam int TW    = $clog2(MAX_FACE_SIZE);
    localparam int FSW   = $clog2(MAX_FACE_SIZE + 1);
    localparam int QW    = COORD_FRAC_BITS + 1;
    localparam int FB    = COORD_FRAC_BITS - 1;     // fractional quotient bits
    localparam int SPS   = 4;                       // quotient bits per stage
    localparam int NDIV  = (FB + SPS - 1) / SPS;
    localparam int PW    = QW + FSW;
    localparam int LAT   = NDIV + 5;
    localparam int FS_RST = (MAX_FACE_SIZE < 256) ? MAX_FACE_SIZE : 256;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [FSW-1:0]                 r_face_size;
    logic [FSW-1:0]                 n_face_size;
    logic [cmfa_pkg::CFG_W-1:0]     cfg_val;
    logic                           cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr == cmfa_pkg::ADDR_FACE_SIZE);
    assign cfg_val = pwdata[cmfa_pkg::CFG_W-1:0];

    // hold 0 as 1 and clip above the largest face
    always_comb begin
        if (cfg_val == '0) begin
            n_face_size = FSW'(1);
        end else if (32'(cfg_val) > 32'(MAX_FACE_SIZE)) begin
            n_face_size = FSW'(MAX_FACE_SIZE);
        end else begin
            n_face_size = FSW'(cfg_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= FSW'(FS_RST);
        end else if (cfg_wr) begin
            r_face_size <= n_face_size;
        end
    end

    assign prdata = (paddr == cmfa_pkg::ADDR_FACE_SIZE) ?
                    cmfa_pkg::APB_DW'(r_face_size) : '0;

    // pipeline never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: capture request, magnitudes
    // ------------------------------------------------------------------
    logic                   r_s1_vld;
    logic signed [DW-1:0]   r_s1_x, r_s1_y, r_s1_z;
    logic [DW-1:0]          r_s1_ax, r_s1_ay, r_s1_az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end

    // -32768 wraps to 0x8000, which is 32768 unsigned
    always_ff @(posedge i_clk) begin
        r_s1_x  <= i_dir_x;
        r_s1_y  <= i_dir_y;
        r_s1_z  <= i_dir_z;
        r_s1_ax <= i_dir_x[DW-1] ? DW'(-i_dir_x) : i_dir_x;
        r_s1_ay <= i_dir_y[DW-1] ? DW'(-i_dir_y) : i_dir_y;
        r_s1_az <= i_dir_z[DW-1] ? DW'(-i_dir_z) : i_dir_z;
    end

    // ------------------------------------------------------------------
    // Stage 2: major axis, face, minor components, numerators
    // ------------------------------------------------------------------
    logic                   r_s2_vld;
    cmfa_pkg::t_face        r_s2_face, n_s2_face;
    logic [DW-1:0]          r_s2_ma, n_s2_ma;
    logic [DW:0]            r_s2_ns, r_s2_nt, n_s2_ns, n_s2_nt;
    logic signed [DW:0]     xs, ys, zs, sc, tc;
    logic signed [DW+1:0]   sum_s, sum_t;

    always_comb begin
        xs = {r_s1_x[DW-1], r_s1_x};
        ys = {r_s1_y[DW-1], r_s1_y};
        zs = {r_s1_z[DW-1], r_s1_z};
        if (r_s1_ax >= r_s1_ay && r_s1_ax >= r_s1_az) begin
            n_s2_ma = r_s1_ax;
            if (!r_s1_x[DW-1]) begin
                n_s2_face = cmfa_pkg::FACE_PX; sc = -zs; tc = -ys;
            end else begin
                n_s2_face = cmfa_pkg::FACE_NX; sc = zs;  tc = -ys;
            end
        end else if (r_s1_ay >= r_s1_ax && r_s1_ay >= r_s1_az) begin
            n_s2_ma = r_s1_ay;
            if (!r_s1_y[DW-1]) begin
                n_s2_face = cmfa_pkg::FACE_PY; sc = xs; tc = zs;
            end else begin
                n_s2_face = cmfa_pkg::FACE_NY; sc = xs; tc = -zs;
            end
        end else begin
            n_s2_ma = r_s1_az;
            if (!r_s1_z[DW-1]) begin
                n_s2_face = cmfa_pkg::FACE_PZ; sc = xs;  tc = -ys;
            end else begin
                n_s2_face = cmfa_pkg::FACE_NZ; sc = -xs; tc = -ys;
            end
        end
        // minor + major lies in 0 .. 2*major
        sum_s = {sc[DW], sc} + $signed({2'b00, n_s2_ma});
        sum_t = {tc[DW], tc} + $signed({2'b00, n_s2_ma});
        n_s2_ns = sum_s[DW:0];
        n_s2_nt = sum_t[DW:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_face <= n_s2_face;
        r_s2_ma   <= n_s2_ma;
        r_s2_ns   <= n_s2_ns;
        r_s2_nt   <= n_s2_nt;
    end

    // ------------------------------------------------------------------
    // Stage 3: integer quotient (0, 1 or 2) and first remainder.
    // Zero vector: divisor 1, quotient one, remainder zero gives s = t = half.
    // ------------------------------------------------------------------
    logic                   r_dvld  [NDIV+1];
    cmfa_pkg::t_face        r_dface [NDIV+1];
    logic                   r_dzero [NDIV+1];
    logic [DW-1:0]          r_dd    [NDIV+1];
    logic [DW-1:0]          r_drs   [NDIV+1];
    logic [DW-1:0]          r_drt   [NDIV+1];
    logic [QW-1:0]          r_dqs   [NDIV+1];
    logic [QW-1:0]          r_dqt   [NDIV+1];

    logic                   zero3;
    logic [DW:0]            ma17, two_ma;
    logic [DW-1:0]          n_s3_rs, n_s3_rt;
    logic [1:0]             n_s3_qs, n_s3_qt;

    always_comb begin
        zero3  = (r_s2_ma == '0);
        ma17   = {1'b0, r_s2_ma};
        two_ma = {r_s2_ma, 1'b0};
        if (zero3) begin
            n_s3_qs = 2'd1; n_s3_rs = '0;
            n_s3_qt = 2'd1; n_s3_rt = '0;
        end else begin
            if (r_s2_ns == two_ma) begin
                n_s3_qs = 2'd2; n_s3_rs = '0;
            end else if (r_s2_ns >= ma17) begin
                n_s3_qs = 2'd1; n_s3_rs = DW'(r_s2_ns - ma17);
            end else begin
                n_s3_qs = 2'd0; n_s3_rs = r_s2_ns[DW-1:0];
            end
            if (r_s2_nt == two_ma) begin
                n_s3_qt = 2'd2; n_s3_rt = '0;
            end else if (r_s2_nt >= ma17) begin
                n_s3_qt = 2'd1; n_s3_rt = DW'(r_s2_nt - ma17);
            end else begin
                n_s3_qt = 2'd0; n_s3_rt = r_s2_nt[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld[0] <= 1'b0;
        end else begin
            r_dvld[0] <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dface[0] <= zero3 ? cmfa_pkg::FACE_PX : r_s2_face;
        r_dzero[0] <= zero3;
        r_dd[0]    <= zero3 ? DW'(1) : r_s2_ma;
        r_drs[0]   <= n_s3_rs;
        r_drt[0]   <= n_s3_rt;
        r_dqs[0]   <= QW'(n_s3_qs);
        r_dqt[0]   <= QW'(n_s3_qt);
    end

    // ------------------------------------------------------------------
    // Division stages: up to SPS restoring steps each for s and t
    // ------------------------------------------------------------------
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        logic [DW-1:0]  n_rs, n_rt;
        logic [QW-1:0]  n_qs, n_qt;
        logic [DW:0]    dbl_s, dbl_t, d17;

        always_comb begin
            n_rs  = r_drs[j];
            n_rt  = r_drt[j];
            n_qs  = r_dqs[j];
            n_qt  = r_dqt[j];
            d17   = {1'b0, r_dd[j]};
            dbl_s = '0;
            dbl_t = '0;
            for (int k = 0; k < SPS; k++) begin
                if (j * SPS + k < FB) begin
                    dbl_s = {n_rs, 1'b0};
                    dbl_t = {n_rt, 1'b0};
                    if (dbl_s >= d17) begin
                        n_rs = DW'(dbl_s - d17);
                        n_qs = {n_qs[QW-2:0], 1'b1};
                    end else begin
                        n_rs = dbl_s[DW-1:0];
                        n_qs = {n_qs[QW-2:0], 1'b0};
                    end
                    if (dbl_t >= d17) begin
                        n_rt = DW'(dbl_t - d17);
                        n_qt = {n_qt[QW-2:0], 1'b1};
                    end else begin
                        n_rt = dbl_t[DW-1:0];
                        n_qt = {n_qt[QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[j+1] <= 1'b0;
            end else begin
                r_dvld[j+1] <= r_dvld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dface[j+1] <= r_dface[j];
            r_dzero[j+1] <= r_dzero[j];
            r_dd[j+1]    <= r_dd[j];
            r_drs[j+1]   <= n_rs;
            r_drt[j+1]   <= n_rt;
            r_dqs[j+1]   <= n_qs;
            r_dqt[j+1]   <= n_qt;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: coordinate times face size
    // ------------------------------------------------------------------
    logic                   r_mvld;
    cmfa_pkg::t_face        r_mface;
    logic                   r_mzero;
    logic [QW-1:0]          r_mqs, r_mqt;
    logic [PW-1:0]          r_mps, r_mpt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else begin
            r_mvld <= r_dvld[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mface <= r_dface[NDIV];
        r_mzero <= r_dzero[NDIV];
        r_mqs   <= r_dqs[NDIV];
        r_mqt   <= r_dqt[NDIV];
        r_mps   <= PW'(r_dqs[NDIV]) * PW'(r_face_size);
        r_mpt   <= PW'(r_dqt[NDIV]) * PW'(r_face_size);
    end

    // ------------------------------------------------------------------
    // Output stage: split into texel and fraction, clamp at coordinate one
    // ------------------------------------------------------------------
    logic [FSW:0]                 int_s, int_t, fs_ext;
    logic [FSW-1:0]               fs_m1;
    logic [TW-1:0]                n_tx, n_ty;
    logic [COORD_FRAC_BITS-1:0]   n_fx, n_fy;

    always_comb begin
        int_s  = r_mps[PW-1:COORD_FRAC_BITS];
        int_t  = r_mpt[PW-1:COORD_FRAC_BITS];
        fs_ext = {1'b0, r_face_size};
        fs_m1  = r_face_size - FSW'(1);
        if (int_s >= fs_ext) begin
            n_tx = TW'(fs_m1);
            n_fx = '1;
        end else begin
            n_tx = TW'(int_s);
            n_fx = r_mps[COORD_FRAC_BITS-1:0];
        end
        if (int_t >= fs_ext) begin
            n_ty = TW'(fs_m1);
            n_fy = '1;
        end else begin
            n_ty = TW'(int_t);
            n_fy = r_mpt[COORD_FRAC_BITS-1:0];
        end
    end

    logic r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_mvld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_face        <= r_mface;
        o_zero_vector <= r_mzero;
        o_coord_s     <= r_mqs;
        o_coord_t     <= r_mqt;
        o_texel_x     <= n_tx;
        o_texel_y     <= n_ty;
        o_frac_x      <= n_fx;
        o_frac_y      <= n_fy;
    end

    assign o_valid = r_ovld;

`ifndef SYNTHESIS
    // every result traces back to an earlier request
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching request");

    // zero vector yields face +X and both coordinates at one half
    a_zero_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |->
        (o_face == cmfa_pkg::FACE_PX && o_coord_s == QW'(1) << FB &&
         o_coord_t == QW'(1) << FB))
        else $error("zero vector default result wrong");

    // coordinates never exceed one
    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coord_s <= QW'(1) << COORD_FRAC_BITS &&
                     o_coord_t <= QW'(1) << COORD_FRAC_BITS))
        else $error("face coordinate above one");

    // texel indices stay below the face size
    a_texel_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (FSW'(o_texel_x) < r_face_size && FSW'(o_texel_y) < r_face_size))
        else $error("texel index not clamped");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/cube_map_face_address_top_test.sv =====
// Self-checking test of cube_map_face_address_top: random and directed direction
// vectors across several face_size settings, results checked field by field.
// Depends on cmfa_pkg and the cube_map_face_address_top RTL.
module cube_map_face_address_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FS      = 4096;
    localparam int CFB         = 16;
    localparam int TEX_W       = $clog2(MAX_FS);
    localparam int DIR_W       = cmfa_pkg::DIR_W;
    localparam int LAT         = 9;
    localparam int STALL_LIMIT = 2000;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 95;

    // byte address that maps to no register
    localparam logic [cmfa_pkg::ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
        logic signed [DIR_W-1:0] z;
    } t_dir;

    typedef struct packed {
        cmfa_pkg::t_face  face;
        logic [CFB:0]     s;
        logic [CFB:0]     t;
        logic [TEX_W-1:0] tx;
        logic [TEX_W-1:0] ty;
        logic [CFB-1:0]   fx;
        logic [CFB-1:0]   fy;
        logic             zero;
    } t_face_addr;

    logic                                i_clk    = 1'b0;
    logic                                i_rst_n  = 1'b0;
    logic                                start    = 1'b0;
    logic                                busy;
    logic signed [DIR_W-1:0]             i_dir_x  = '0;
    logic signed [DIR_W-1:0]             i_dir_y  = '0;
    logic signed [DIR_W-1:0]             i_dir_z  = '0;
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [cmfa_pkg::ADDR_W-1:0]         paddr    = '0;
    logic [cmfa_pkg::APB_DW-1:0]         pwdata   = '0;
    logic [cmfa_pkg::APB_DW-1:0]         prdata;
    logic                                pready;
    logic                                o_valid;
    logic [cmfa_pkg::FACE_W-1:0]         o_face;
    logic [CFB:0]                        o_coord_s;
    logic [CFB:0]                        o_coord_t;
    logic [TEX_W-1:0]                    o_texel_x;
    logic [TEX_W-1:0]                    o_texel_y;
    logic [CFB-1:0]                      o_frac_x;
    logic [CFB-1:0]                      o_frac_y;
    logic                                o_zero_vector;

    t_dir       dir_pending_q[$];
    t_face_addr face_addr_q[$];
    t_face_addr staged_addr;
    logic       staged_vld    = 1'b0;
    int         face_size_cfg = 256;
    int         gap_left      = 0;
    int         burst_left    = 0;
    int         fail_cnt      = 0;
    int         stall_cycles  = 0;

    cube_map_face_address_top #(
        .MAX_FACE_SIZE   (MAX_FS),
        .COORD_FRAC_BITS (CFB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_valid       (o_valid),
        .o_face        (o_face),
        .o_coord_s     (o_coord_s),
        .o_coord_t     (o_coord_t),
        .o_texel_x     (o_texel_x),
        .o_texel_y     (o_texel_y),
        .o_frac_x      (o_frac_x),
        .o_frac_y      (o_frac_y),
        .o_zero_vector (o_zero_vector)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // (minor + major) / (2 * major) in Q1.16, truncated
    function automatic longint face_coord(int minor, int major);
        return ((longint'(minor) + major) <<< (CFB - 1)) / major;
    endfunction

    // scale a coordinate by the face size, clamp just below the edge
    function automatic void scale_coord(input longint c, input int fs,
                                        output logic [TEX_W-1:0] texel,
                                        output logic [CFB-1:0] frac);
        longint pos;
        pos = c * fs;
        if ((pos >>> CFB) >= fs) begin
            texel = TEX_W'(fs - 1);
            frac  = '1;
        end else begin
            texel = TEX_W'(pos >>> CFB);
            frac  = pos[CFB-1:0];
        end
    endfunction

    // major-axis face select and face address for one direction
    function automatic t_face_addr map_direction(t_dir d, int fs);
        int x, y, z, ax, ay, az, ma, sc, tc;
        longint sv, tv;
        t_face_addr r;
        x  = int'(d.x);
        y  = int'(d.y);
        z  = int'(d.z);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        if (ax >= ay && ax >= az) begin
            ma = ax;
            if (x >= 0) begin
                r.face = cmfa_pkg::FACE_PX; sc = -z; tc = -y;
            end else begin
                r.face = cmfa_pkg::FACE_NX; sc = z;  tc = -y;
            end
        end else if (ay >= ax && ay >= az) begin
            ma = ay;
            if (y >= 0) begin
                r.face = cmfa_pkg::FACE_PY; sc = x; tc = z;
            end else begin
                r.face = cmfa_pkg::FACE_NY; sc = x; tc = -z;
            end
        end else begin
            ma = az;
            if (z >= 0) begin
                r.face = cmfa_pkg::FACE_PZ; sc = x;  tc = -y;
            end else begin
                r.face = cmfa_pkg::FACE_NZ; sc = -x; tc = -y;
            end
        end
        // all-zero vector: default face and the face center
        if (ma == 0) begin
            r.zero = 1'b1;
            r.face = cmfa_pkg::FACE_PX;
            sv     = longint'(1) <<< (CFB - 1);
            tv     = sv;
        end else begin
            r.zero = 1'b0;
            sv     = face_coord(sc, ma);
            tv     = face_coord(tc, ma);
        end
        r.s = sv[CFB:0];
        r.t = tv[CFB:0];
        scale_coord(sv, fs, r.tx, r.fx);
        scale_coord(tv, fs, r.ty, r.fy);
        return r;
    endfunction

    // idle cycles after a request: mostly none or short, some long, some bursts
    function automatic int pick_gap();
        int k;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        k = $urandom_range(99);
        if (k < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (k < 55) return 0;
        if (k < 85) return $urandom_range(1, 3);
        if (k < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // magnitude 0..32768 with a random sign (32768 only exists negative)
    function automatic logic signed [DIR_W-1:0] signed_mag(int m);
        if (m >= 32768) return 16'sh8000;
        return ($urandom_range(0, 1) != 0) ? DIR_W'(-m) : DIR_W'(m);
    endfunction

    function automatic t_dir rand_dir();
        int k, m, p;
        int c[3];
        int extremes[6];
        t_dir d;
        extremes = '{-32768, -32767, -1, 0, 1, 32767};
        k = $urandom_range(99);
        if (k < 45) begin
            // full range
            d.x = DIR_W'($urandom);
            d.y = DIR_W'($urandom);
            d.z = DIR_W'($urandom);
        end else if (k < 60) begin
            // tiny components: zero vectors and ties near the origin
            d.x = DIR_W'(int'($urandom_range(0, 8)) - 4);
            d.y = DIR_W'(int'($urandom_range(0, 8)) - 4);
            d.z = DIR_W'(int'($urandom_range(0, 8)) - 4);
        end else if (k < 90) begin
            // ties and near-ties of the major axis, coordinates near 0 and 1
            m    = $urandom_range(0, 32768);
            c[0] = m;
            if (k < 78) c[1] = m;
            else c[1] = m - int'($urandom_range(0, (m < 3) ? m : 3));
            c[2] = ($urandom_range(0, 2) == 0) ? m : int'($urandom_range(0, m));
            p    = $urandom_range(0, 2);
            d.x  = signed_mag(c[p]);
            d.y  = signed_mag(c[(p + 1) % 3]);
            d.z  = signed_mag(c[(p + 2) % 3]);
        end else begin
            d.x = DIR_W'(extremes[$urandom_range(0, 5)]);
            d.y = DIR_W'(extremes[$urandom_range(0, 5)]);
            d.z = DIR_W'(extremes[$urandom_range(0, 5)]);
        end
        return d;
    endfunction

    // driver: issue pending requests, predict each accepted one
    always @(posedge i_clk) begin
        t_dir nxt;
        logic drive;
        if (!i_rst_n) begin
            start      <= 1'b0;
            staged_vld <= 1'b0;
        end else begin
            drive = start;
            staged_vld <= start && !busy;
            if (start && !busy) begin
                staged_addr <= map_direction(t_dir'{i_dir_x, i_dir_y, i_dir_z},
                                             face_size_cfg);
                drive = 1'b0;
            end
            if (!drive) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (dir_pending_q.size() > 0) begin
                    nxt = dir_pending_q.pop_front();
                    i_dir_x <= nxt.x;
                    i_dir_y <= nxt.y;
                    i_dir_z <= nxt.z;
                    drive    = 1'b1;
                    gap_left = pick_gap();
                end
            end
            start <= drive;
        end
    end

    // monitor: check each result against the oldest expected address
    always @(posedge i_clk) begin
        t_face_addr want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (face_addr_q.size() == 0) begin
                    $error("result with no request outstanding: face %0d", o_face);
                    fail_cnt++;
                end else begin
                    want = face_addr_q.pop_front();
                    if (o_face !== want.face) begin
                        $error("face: expected %0d, got %0d", want.face, o_face);
                        fail_cnt++;
                    end
                    if (o_coord_s !== want.s) begin
                        $error("coord_s: expected %0d, got %0d", want.s, o_coord_s);
                        fail_cnt++;
                    end
                    if (o_coord_t !== want.t) begin
                        $error("coord_t: expected %0d, got %0d", want.t, o_coord_t);
                        fail_cnt++;
                    end
                    if (o_texel_x !== want.tx) begin
                        $error("texel_x: expected %0d, got %0d", want.tx, o_texel_x);
                        fail_cnt++;
                    end
                    if (o_texel_y !== want.ty) begin
                        $error("texel_y: expected %0d, got %0d", want.ty, o_texel_y);
                        fail_cnt++;
                    end
                    if (o_frac_x !== want.fx) begin
                        $error("frac_x: expected %0d, got %0d", want.fx, o_frac_x);
                        fail_cnt++;
                    end
                    if (o_frac_y !== want.fy) begin
                        $error("frac_y: expected %0d, got %0d", want.fy, o_frac_y);
                        fail_cnt++;
                    end
                    if (o_zero_vector !== want.zero) begin
                        $error("zero_vector: expected %0d, got %0d",
                               want.zero, o_zero_vector);
                        fail_cnt++;
                    end
                end
            end
            // a request accepted last edge joins the queue after this check
            if (staged_vld) face_addr_q.push_back(staged_addr);
        end
    end

    // watchdog: no progress while work is outstanding
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid ||
            (dir_pending_q.size() == 0 && !start && !staged_vld &&
             face_addr_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("cube_map_face_address_top_test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // wait until every request has been answered and the pipeline is empty
    task automatic wait_drained();
        @(negedge i_clk);
        while (dir_pending_q.size() != 0 || start || staged_vld ||
               face_addr_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LAT) @(posedge i_clk);
    endtask

    // APB write: setup then access, mirror the register on completion
    task automatic cfg_write(logic [cmfa_pkg::ADDR_W-1:0] addr,
                             logic [cmfa_pkg::APB_DW-1:0] data);
        int v;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == cmfa_pkg::ADDR_FACE_SIZE) begin
            v = int'(data[cmfa_pkg::CFG_W-1:0]);
            if (v < 1) v = 1;
            if (v > MAX_FS) v = MAX_FS;
            face_size_cfg = v;
        end
    endtask

    task automatic push_dir(int x, int y, int z);
        t_dir d;
        d.x = DIR_W'(x);
        d.y = DIR_W'(y);
        d.z = DIR_W'(z);
        dir_pending_q.push_back(d);
    endtask

    // sequence: directed vectors at reset face size, then random phases
    initial begin
        logic [cmfa_pkg::ADDR_W-1:0] ph_addr[N_PHASES];
        logic [cmfa_pkg::APB_DW-1:0] ph_data[N_PHASES];
        ph_addr = '{cmfa_pkg::ADDR_FACE_SIZE, cmfa_pkg::ADDR_FACE_SIZE,
                    cmfa_pkg::ADDR_FACE_SIZE, cmfa_pkg::ADDR_FACE_SIZE,
                    cmfa_pkg::ADDR_FACE_SIZE, ADDR_UNMAPPED,
                    cmfa_pkg::ADDR_FACE_SIZE, cmfa_pkg::ADDR_FACE_SIZE,
                    cmfa_pkg::ADDR_FACE_SIZE, cmfa_pkg::ADDR_FACE_SIZE};
        ph_data = '{32'd1, 32'd4096, 32'd0, 32'd8191, 32'hFFFF_E007, 32'd3,
                    32'd2, 32'd4095, $urandom_range(1, MAX_FS), 32'd3};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        // zero vector, one vector per face
        push_dir(0, 0, 0);
        push_dir(16384, 100, -200);
        push_dir(-16384, 100, 200);
        push_dir(50, 16384, -70);
        push_dir(50, -16384, -70);
        push_dir(-30, 40, 16384);
        push_dir(-30, 40, -16384);
        // tie breaks toward X, then Y
        push_dir(1000, 1000, 1000);
        push_dir(-1000, 1000, -1000);
        push_dir(5, -2000, 2000);
        push_dir(2000, 2000, 5);
        // component extremes
        push_dir(32767, 32767, 32767);
        push_dir(-32768, -32768, -32768);
        push_dir(-32768, 32767, 0);
        push_dir(0, -32768, 32767);
        push_dir(0, 0, -32768);
        push_dir(32767, -32768, 0);
        // coordinate at one (clamped) and at zero
        push_dir(16384, 0, -16384);
        push_dir(16384, 16384, 0);
        // smallest nonzero vectors, then one general vector
        push_dir(1, 0, 0);
        push_dir(0, -1, 0);
        push_dir(0, 0, 1);
        push_dir(-1, 1, -1);
        push_dir(12345, -6789, 3210);
        wait_drained();

        // each phase starts from an idle pipeline
        for (int p = 0; p < N_PHASES; p++) begin
            cfg_write(ph_addr[p], ph_data[p]);
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++) dir_pending_q.push_back(rand_dir());
            wait_drained();
        end

        repeat (2 * LAT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("cube_map_face_address_top_test passed");
        end else begin
            $display("cube_map_face_address_top_test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cmfa_pkg.sv
hdl/cube_map_face_address_top.sv
tb/sv/cube_map_face_address_top_test.sv
